/* rtl/dupd_pkg.sv */
// shared types and constants for the dual ultrasonic presence detector
package dupd_pkg;

    // request kinds on the item channel
    localparam logic ACTION_EDGE = 1'b0;
    localparam logic ACTION_POLL = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOSE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 2'd2;
    localparam int CFG_DATA_W = 32;

    // field widths
    localparam int NOW_W      = 32;
    localparam int DIST_W     = 16;
    localparam int DEBOUNCE_W = 32;
    localparam int TICK_LO_W  = 16;

    // register reset values
    localparam int CLOSE_RESET_CM = 18;
    localparam int FAR_RESET_CM   = 22;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 32'd5000;

    // distance = ticks * 100 / 58, saturated
    localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;
    // first tick count whose distance no longer fits in 16 bits
    localparam logic [TICK_LO_W-1:0] SAT_TICKS = 16'd38011;
    // ceil(2^28 / 58) * 100, exact for every product below 2^22
    localparam int PROD_W     = 45;
    localparam int DIST_SHIFT = 28;
    localparam logic [PROD_W-1:0] DIST_RECIP = 45'd462819800;

    // thresholds are compared in the tick domain: dist < c  <=>  ticks * 50 < c * 29
    localparam int SCALED_W   = 21;
    localparam int TSCALED_W  = 22;
    localparam int SCALE_TICK = 50;
    localparam int SCALE_CM   = 29;
    localparam logic [SCALED_W-1:0] CLOSE_SCALED_RESET = SCALED_W'(CLOSE_RESET_CM * SCALE_CM);
    localparam logic [SCALED_W-1:0] FAR_SCALED_RESET   = SCALED_W'(FAR_RESET_CM * SCALE_CM);

    typedef struct packed {
        logic             action;
        logic             sensor;
        logic [NOW_W-1:0] now;
        logic             paused;
    } item_t;

    typedef struct packed {
        logic              fire_valid;
        logic              fire_sensor;
        logic              measured_valid;
        logic [DIST_W-1:0] distance_cm;
        logic              arrived_valid;
        logic              arrived_sensor;
        logic [1:0]        present_mask;
    } result_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              near;
        logic              far;
    } range_t;

endpackage

/* rtl/dupd_range.sv */
// echo duration to distance conversion and threshold classification
module dupd_range
    import dupd_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic [TIME_BITS-1:0] ticks,
    input  logic [SCALED_W-1:0]  close_scaled,
    input  logic [SCALED_W-1:0]  far_scaled,
    output range_t               rng
);

    localparam int TW = (TIME_BITS > TICK_LO_W) ? TIME_BITS : TICK_LO_W + 1;

    logic [TW-1:0]        ticks_ext;
    logic [TICK_LO_W-1:0] ticks_lo;
    logic                 wide;
    logic                 sat;
    logic [PROD_W-1:0]    prod;
    logic [TSCALED_W-1:0] ticks_scaled;

    // split off counts that are far out of range
    assign ticks_ext = TW'(ticks);
    assign ticks_lo  = ticks_ext[TICK_LO_W-1:0];
    assign wide      = |ticks_ext[TW-1:TICK_LO_W];
    assign sat       = wide || (ticks_lo >= SAT_TICKS);

    // reciprocal multiply for ticks * 100 / 58
    assign prod = PROD_W'(ticks_lo) * DIST_RECIP;
    assign rng.distance = sat ? DIST_MAX : prod[DIST_SHIFT+DIST_W-1:DIST_SHIFT];

    // near and far tests against pre-scaled thresholds
    assign ticks_scaled = TSCALED_W'(ticks_lo) * TSCALED_W'(SCALE_TICK);
    assign rng.near = !wide && (ticks_scaled < TSCALED_W'(close_scaled));
    assign rng.far  = wide || (ticks_scaled >= TSCALED_W'(far_scaled));

endmodule

/* rtl/dupd_track.sv */
// per-sensor echo, presence and ping state with the one-step update
module dupd_track
    import dupd_pkg::*;
#(
    parameter int SENSOR_COUNT = 2,
    parameter int TIME_BITS    = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  item_t                 item,
    input  logic [SCALED_W-1:0]   close_scaled,
    input  logic [SCALED_W-1:0]   far_scaled,
    input  logic [DEBOUNCE_W-1:0] debounce,
    output result_t               result
);

    localparam int SW = $clog2(SENSOR_COUNT);
    localparam int DW = (TIME_BITS > DEBOUNCE_W) ? TIME_BITS : DEBOUNCE_W;

    logic [TIME_BITS-1:0] start_reg      [SENSOR_COUNT];
    logic [TIME_BITS-1:0] start_next     [SENSOR_COUNT];
    logic [TIME_BITS-1:0] close_time_reg [SENSOR_COUNT];
    logic [TIME_BITS-1:0] close_time_next[SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] armed_reg;
    logic [SENSOR_COUNT-1:0] armed_next;
    logic [SENSOR_COUNT-1:0] present_reg;
    logic [SENSOR_COUNT-1:0] present_next;
    logic [SENSOR_COUNT-1:0] pending_reg;
    logic [SENSOR_COUNT-1:0] pending_next;
    logic [SW-1:0]           active_reg;
    logic [SW-1:0]           active_next;
    logic [SW-1:0]           following;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] ticks;
    logic [TIME_BITS-1:0] since_close;
    logic                 debounced;
    logic                 is_active;
    logic                 found;
    logic [SW-1:0]        sel;
    range_t               rng;

    // current sensor timing
    assign now_t       = TIME_BITS'(item.now);
    assign is_active   = (SW'(item.sensor) == active_reg);
    assign ticks       = now_t - start_reg[active_reg];
    assign since_close = now_t - close_time_reg[active_reg];
    assign debounced   = DW'(since_close) > DW'(debounce);
    assign following   = (active_reg == SW'(SENSOR_COUNT - 1)) ? '0 : active_reg + 1'b1;

    dupd_range #(
        .TIME_BITS (TIME_BITS)
    ) u_range (
        .ticks        (ticks),
        .close_scaled (close_scaled),
        .far_scaled   (far_scaled),
        .rng          (rng)
    );

    // lowest pending sensor
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = SENSOR_COUNT - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                found = 1'b1;
                sel   = SW'(i);
            end
        end
    end

    // next state and result for the request in the input register
    always_comb
    begin
        start_next      = start_reg;
        close_time_next = close_time_reg;
        armed_next      = armed_reg;
        present_next    = present_reg;
        pending_next    = pending_reg;
        active_next     = active_reg;
        result          = '0;

        if (item.action == ACTION_EDGE)
        begin
            if (is_active)
            begin
                if (!armed_reg[active_reg])
                begin
                    start_next[active_reg] = now_t;
                    armed_next[active_reg] = 1'b1;
                end
                else
                begin
                    armed_next[active_reg] = 1'b0;
                    result.measured_valid  = 1'b1;
                    result.distance_cm     = rng.distance;
                    // presence with hysteresis and debounce
                    if (!present_reg[active_reg] && rng.near)
                    begin
                        present_next[active_reg]    = 1'b1;
                        close_time_next[active_reg] = now_t;
                        result.arrived_valid        = 1'b1;
                        result.arrived_sensor       = active_reg[0];
                    end
                    else if (present_reg[active_reg] && rng.near)
                    begin
                        close_time_next[active_reg] = now_t;
                    end
                    else if (present_reg[active_reg] && rng.far && debounced)
                    begin
                        present_next[active_reg] = 1'b0;
                    end
                    // hand over to the next sensor
                    active_next             = following;
                    pending_next[following] = 1'b1;
                end
            end
        end
        else
        begin
            if (found && !item.paused)
            begin
                pending_next[sel]  = 1'b0;
                result.fire_valid  = 1'b1;
                result.fire_sensor = sel[0];
            end
        end

        result.present_mask = {present_next[1], present_next[0]};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= '0;
            present_reg <= '0;
            pending_reg <= '0;
            active_reg  <= '0;
        end
        else if (step)
        begin
            armed_reg   <= armed_next;
            present_reg <= present_next;
            pending_reg <= pending_next;
            active_reg  <= active_next;
        end
    end

    // timestamps, only read after being written
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            start_reg      <= start_next;
            close_time_reg <= close_time_next;
        end
    end

endmodule

/* rtl/dual_ultrasonic_presence_detector.sv */
// top level of the dual ultrasonic presence detector
//
// Takes one request per clock (echo edge or trigger poll) and returns exactly one
// result per request, in order. A request waits in the input register until the output
// register can take its result, which the state update in the tracker computes
// combinationally and which is then held in the output register until taken;
// throughput is one request per cycle with no gaps as long as results are taken.
// The per-sensor state update is the path that sets this rate.
// Distance is ticks*100/58 cm saturated at 65535. Configuration writes are always
// accepted and must only be issued while no request is in flight. No clearing pass
// is needed after reset.
module dual_ultrasonic_presence_detector
    import dupd_pkg::*;
#(
    parameter int SENSOR_COUNT = 2,
    parameter int TIME_BITS    = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic                   action,
    input  logic                   sensor,
    input  logic [NOW_W-1:0]       now,
    input  logic                   paused,

    output logic                   result_valid,
    input  logic                   result_ready,
    output logic                   fire_valid,
    output logic                   fire_sensor,
    output logic                   measured_valid,
    output logic [DIST_W-1:0]      distance_cm,
    output logic                   arrived_valid,
    output logic                   arrived_sensor,
    output logic [1:0]             present_mask,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    item_t                 item_reg;
    logic                  item_valid_reg;
    result_t               result_reg;
    result_t               step_result;
    logic                  result_valid_reg;
    logic                  advance;
    logic [SCALED_W-1:0]   close_scaled_reg;
    logic [SCALED_W-1:0]   far_scaled_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [SCALED_W-1:0]   cfg_scaled;

    // handshake
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= '{action: action, sensor: sensor, now: now, paused: paused};
        end
    end

    // configuration registers, thresholds kept pre-scaled to the tick domain
    assign cfg_scaled = SCALED_W'(cfg_data[DIST_W-1:0]) * SCALED_W'(SCALE_CM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_scaled_reg <= CLOSE_SCALED_RESET;
            far_scaled_reg   <= FAR_SCALED_RESET;
            debounce_reg     <= DEBOUNCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLOSE:    close_scaled_reg <= cfg_scaled;
                CFG_FAR:      far_scaled_reg   <= cfg_scaled;
                CFG_DEBOUNCE: debounce_reg     <= cfg_data[DEBOUNCE_W-1:0];
                default:      ;
            endcase
        end
    end

    dupd_track #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .TIME_BITS    (TIME_BITS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (item_reg),
        .close_scaled (close_scaled_reg),
        .far_scaled   (far_scaled_reg),
        .debounce     (debounce_reg),
        .result       (step_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid   = result_valid_reg;
    assign fire_valid     = result_reg.fire_valid;
    assign fire_sensor    = result_reg.fire_sensor;
    assign measured_valid = result_reg.measured_valid;
    assign distance_cm    = result_reg.distance_cm;
    assign arrived_valid  = result_reg.arrived_valid;
    assign arrived_sensor = result_reg.arrived_sensor;
    assign present_mask   = result_reg.present_mask;

`ifndef SYNTH
    // a request that moves on always shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> result_valid_reg)
        else $error("advanced request did not reach the output register");

    // the input side only stalls on output backpressure
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (result_valid_reg && !result_ready))
        else $error("input stalled without output backpressure");

    // a poll fire and a measurement never come from the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(fire_valid && measured_valid))
        else $error("fire and measurement in one result");

    // an arrival comes with a measurement and a set presence bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && arrived_valid) |->
            (measured_valid && present_mask[arrived_sensor]))
        else $error("arrival without measurement or presence");
`endif

endmodule
